// ===== design/bec_pkg.sv =====
`default_nettype none

package bec_pkg;

  // Width of the configuration write data and of every 16-bit field.
  localparam int DATA_W = 16;
  localparam int IDX_W  = 3;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_MAX_COUNT     = 3'd0;
  localparam logic [IDX_W-1:0] REG_CURVE_MODE    = 3'd1;
  localparam logic [IDX_W-1:0] REG_START_Y       = 3'd2;
  localparam logic [IDX_W-1:0] REG_FIRST_CTRL_Y  = 3'd3;
  localparam logic [IDX_W-1:0] REG_SECOND_CTRL_Y = 3'd4;
  localparam logic [IDX_W-1:0] REG_END_Y         = 3'd5;

  // Curve mode codes.
  localparam logic MODE_LINEAR = 1'b0;
  localparam logic MODE_BEZIER = 1'b1;

  // One classified step as it travels from the front end to the back end.
  typedef struct packed {
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] maxc;
    logic              clamp;
  } item_t;

  // Curve settings that the back end reads.
  typedef struct packed {
    logic              mode;
    logic [DATA_W-1:0] p0;
    logic [DATA_W-1:0] p1;
    logic [DATA_W-1:0] p2;
    logic [DATA_W-1:0] p3;
  } coef_t;

endpackage

`default_nettype wire

// ===== design/bezier_easing_curve.sv =====
`default_nettype none

// Cubic Bezier easing evaluator. Each step_count transaction yields one result:
// progress t = floor(step_count * 2^FRAC_BITS / max_count) in Q1.FRAC_BITS,
// saturated to 1.0 with clamped set when the step passes max_count (a zero
// max_count acts as one). In linear mode progress is t itself; in curve mode it
// is the rounded cubic Bernstein blend of the four control y values at t. The
// block takes one step per clock and returns one result per clock for as long
// as result_stall stays low. An accepted step passes through the input stage
// register and the queue, then the divider, which resolves one quotient bit
// per pipeline stage, then four multiply and add stages and the output
// register. A four-entry queue between the input stage and the arithmetic
// pipeline absorbs stalls. Configuration writes are taken at any
// time but must only be issued while no step is in flight.
module bezier_easing_curve #(
  parameter int FRAC_BITS = 15
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       wr_en,
  input  wire logic [bec_pkg::IDX_W-1:0]  wr_index,
  input  wire logic [bec_pkg::DATA_W-1:0] wr_data,
  input  wire logic                       step_valid,
  output logic                            step_stall,
  input  wire logic [bec_pkg::DATA_W-1:0] step_count,
  output logic                            result_valid,
  input  wire logic                       result_stall,
  output logic [bec_pkg::DATA_W-1:0]      progress,
  output logic                            clamped
);

  localparam int DW = bec_pkg::DATA_W;
  localparam logic [DW-1:0] ONE_Q = DW'(1) << FRAC_BITS;

  logic [DW-1:0]  max_count;
  logic           curve_mode;
  logic [DW-1:0]  start_y;
  logic [DW-1:0]  first_ctrl_y;
  logic [DW-1:0]  second_ctrl_y;
  logic [DW-1:0]  end_y;

  bec_pkg::item_t front_item;
  logic           front_valid;
  logic           queue_full;
  bec_pkg::item_t queue_item;
  logic           queue_valid;
  logic           queue_pop;
  bec_pkg::coef_t coef;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_count     <= '1;
      curve_mode    <= bec_pkg::MODE_BEZIER;
      start_y       <= '0;
      first_ctrl_y  <= '0;
      second_ctrl_y <= ONE_Q;
      end_y         <= ONE_Q;
    end else if (wr_en) begin
      case (wr_index)
        bec_pkg::REG_MAX_COUNT:     max_count     <= wr_data;
        bec_pkg::REG_CURVE_MODE:    curve_mode    <= wr_data[0];
        bec_pkg::REG_START_Y:       start_y       <= wr_data;
        bec_pkg::REG_FIRST_CTRL_Y:  first_ctrl_y  <= wr_data;
        bec_pkg::REG_SECOND_CTRL_Y: second_ctrl_y <= wr_data;
        bec_pkg::REG_END_Y:         end_y         <= wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    coef.mode = curve_mode;
    coef.p0   = start_y;
    coef.p1   = first_ctrl_y;
    coef.p2   = second_ctrl_y;
    coef.p3   = end_y;
  end

  // Input stage: accepts and classifies steps.
  bec_front u_front (
    .clk        (clk),
    .rst        (rst),
    .step_valid (step_valid),
    .step_stall (step_stall),
    .step_count (step_count),
    .max_count  (max_count),
    .item       (front_item),
    .item_valid (front_valid),
    .queue_full (queue_full)
  );

  // Decoupling queue.
  bec_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_item  (front_item),
    .full       (queue_full),
    .pop        (queue_pop),
    .pop_item   (queue_item),
    .pop_valid  (queue_valid)
  );

  // Divider and Bernstein blend pipeline.
  bec_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .item         (queue_item),
    .item_valid   (queue_valid),
    .item_pop     (queue_pop),
    .coef         (coef),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .progress     (progress),
    .clamped      (clamped)
  );

endmodule

`default_nettype wire

// ===== design/bec_front.sv =====
`default_nettype none

module bec_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       step_valid,
  output logic                            step_stall,
  input  wire logic [bec_pkg::DATA_W-1:0] step_count,
  input  wire logic [bec_pkg::DATA_W-1:0] max_count,
  output bec_pkg::item_t                  item,
  output logic                            item_valid,
  input  wire logic                       queue_full
);

  logic           f_valid;
  logic           f_valid_next;
  bec_pkg::item_t f_item;
  bec_pkg::item_t f_item_next;
  logic           accept;
  logic           push;

  // A held step leaves as soon as the queue has room.
  assign push       = f_valid && !queue_full;
  assign step_stall = f_valid && queue_full;
  assign accept     = step_valid && !step_stall;

  // Classify the step: a zero limit acts as one, and steps past the limit saturate.
  always_comb begin
    f_item_next.maxc  = (max_count == '0) ? bec_pkg::DATA_W'(1) : max_count;
    f_item_next.count = step_count;
    f_item_next.clamp = (step_count > f_item_next.maxc);
    if (accept) begin
      f_valid_next = 1'b1;
    end else if (push) begin
      f_valid_next = 1'b0;
    end else begin
      f_valid_next = f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= f_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item <= f_item_next;
    end
  end

  assign item       = f_item;
  assign item_valid = f_valid;

endmodule

`default_nettype wire

// ===== design/bec_queue.sv =====
`default_nettype none

module bec_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  input  wire bec_pkg::item_t push_item,
  output logic                full,
  input  wire logic           pop,
  output bec_pkg::item_t      pop_item,
  output logic                pop_valid
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;

  bec_pkg::item_t   mem [0:DEPTH-1];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] cnt;
  logic             push;

  assign full      = (cnt == CNT_W'(DEPTH));
  assign pop_valid = (cnt != '0);
  assign push      = push_valid && !full;
  assign pop_item  = mem[rd_ptr];

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== design/bec_back.sv =====
`default_nettype none

module bec_back #(
  parameter int FRAC_BITS = 15
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire bec_pkg::item_t             item,
  input  wire logic                       item_valid,
  output logic                            item_pop,
  input  wire bec_pkg::coef_t             coef,
  output logic                            result_valid,
  input  wire logic                       result_stall,
  output logic [bec_pkg::DATA_W-1:0]      progress,
  output logic                            clamped
);

  localparam int DW    = bec_pkg::DATA_W;
  localparam int TW    = FRAC_BITS + 1;
  localparam int NDIV  = FRAC_BITS + 2;
  localparam int AW    = TW + DW;
  localparam int PW    = 2 * TW;
  localparam int SW    = 3 * TW + DW;
  localparam int SHIFT = 3 * FRAC_BITS;
  localparam logic [TW-1:0] ONE   = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [SW-1:0] ROUND = SW'(1) << (SHIFT - 1);

  logic adv;

  // Divider stages: restoring division, one quotient bit per stage.
  logic          dv [0:NDIV-1];
  logic [DW:0]   dr [0:NDIV-1];
  logic [TW-1:0] dq [0:NDIV-1];
  logic [DW-1:0] dm [0:NDIV-1];
  logic          dc [0:NDIV-1];
  logic [DW:0]   dr_next [0:NDIV-2];
  logic [TW-1:0] dq_next [0:NDIV-2];

  // Blend stages.
  logic          m1_v, m1_c;
  logic [TW-1:0] m1_t, m1_u;
  logic          m2_v, m2_c;
  logic [TW-1:0] m2_t;
  logic [PW-1:0] m2_u2, m2_t2;
  logic [AW-1:0] m2_a0, m2_a1, m2_a2, m2_a3;
  logic          m3_v, m3_c;
  logic [TW-1:0] m3_t;
  logic [SW-1:0] m3_b0, m3_b1, m3_b2, m3_b3;
  logic          m4_v, m4_c;
  logic [TW-1:0] m4_t;
  logic [SW-1:0] m4_s01, m4_s23;
  logic [SW-1:0] rsum;
  logic [TW-1:0] t_div;

  // The whole back end moves together unless a finished result is held.
  assign adv      = !(result_valid && result_stall);
  assign item_pop = item_valid && adv;

  // Each divider stage shifts the remainder (except the first) and subtracts if it fits.
  always_comb begin
    logic [DW:0] rr;
    logic        qbit;
    for (int k = 0; k < NDIV - 1; k++) begin
      rr            = (k == 0) ? dr[k] : {dr[k][DW-1:0], 1'b0};
      qbit          = (rr >= {1'b0, dm[k]});
      dr_next[k]    = qbit ? (rr - {1'b0, dm[k]}) : rr;
      dq_next[k]    = {dq[k][TW-2:0], qbit};
    end
  end

  // Valid bits of every stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NDIV; k++) begin
        dv[k] <= 1'b0;
      end
      m1_v         <= 1'b0;
      m2_v         <= 1'b0;
      m3_v         <= 1'b0;
      m4_v         <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      dv[0] <= item_valid;
      for (int k = 0; k < NDIV - 1; k++) begin
        dv[k+1] <= dv[k];
      end
      m1_v         <= dv[NDIV-1];
      m2_v         <= m1_v;
      m3_v         <= m2_v;
      m4_v         <= m3_v;
      result_valid <= m4_v;
    end
  end

  assign t_div = dc[NDIV-1] ? ONE : dq[NDIV-1];

  // Sum of the four Bernstein terms plus the rounding half.
  assign rsum = m4_s01 + m4_s23 + ROUND;

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      dr[0] <= {1'b0, item.count};
      dq[0] <= '0;
      dm[0] <= item.maxc;
      dc[0] <= item.clamp;
      for (int k = 0; k < NDIV - 1; k++) begin
        dr[k+1] <= dr_next[k];
        dq[k+1] <= dq_next[k];
        dm[k+1] <= dm[k];
        dc[k+1] <= dc[k];
      end

      // Progress t and its complement u.
      m1_t <= t_div;
      m1_u <= ONE - t_div;
      m1_c <= dc[NDIV-1];

      // Squares and the control values weighted by one power.
      m2_u2 <= m1_u * m1_u;
      m2_t2 <= m1_t * m1_t;
      m2_a0 <= m1_u * coef.p0;
      m2_a1 <= m1_t * coef.p1;
      m2_a2 <= m1_u * coef.p2;
      m2_a3 <= m1_t * coef.p3;
      m2_t  <= m1_t;
      m2_c  <= m1_c;

      // Full cubic terms.
      m3_b0 <= m2_u2 * m2_a0;
      m3_b1 <= m2_u2 * m2_a1;
      m3_b2 <= m2_t2 * m2_a2;
      m3_b3 <= m2_t2 * m2_a3;
      m3_t  <= m2_t;
      m3_c  <= m2_c;

      // Pairwise sums with the binomial weight of three on the middle terms.
      m4_s01 <= m3_b0 + m3_b1 + (m3_b1 << 1);
      m4_s23 <= m3_b2 + (m3_b2 << 1) + m3_b3;
      m4_t   <= m3_t;
      m4_c   <= m3_c;

      // Output register.
      progress <= (coef.mode == bec_pkg::MODE_BEZIER) ? rsum[SHIFT +: DW] : DW'(m4_t);
      clamped  <= m4_c;
    end
  end

endmodule

`default_nettype wire
